FILE: design/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that a trigger implies a consequence in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/lcd4_pkg.sv
// Shared types, codes and microprogram for the 4-bit character LCD sequencer.
package lcd4_pkg;

    // Request codes
    localparam logic [2:0] OP_CMD   = 3'd0;
    localparam logic [2:0] OP_DATA  = 3'd1;
    localparam logic [2:0] OP_GOTO  = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;
    localparam logic [2:0] OP_INIT  = 3'd4;

    // Configuration register indexes
    localparam logic CFG_ENABLE_HIGH   = 1'b0;
    localparam logic CFG_ENABLE_SETTLE = 1'b1;

    // Reset values of the timing registers
    localparam logic [7:0] ENABLE_HIGH_RESET   = 8'd2;
    localparam logic [9:0] ENABLE_SETTLE_RESET = 10'd50;

    localparam int PC_W   = 4;
    localparam int HOLD_W = 13;

    // Microprogram entry points
    localparam logic [PC_W-1:0] ENTRY_BYTE  = 4'd0;
    localparam logic [PC_W-1:0] ENTRY_CLEAR = 4'd2;
    localparam logic [PC_W-1:0] ENTRY_INIT  = 4'd4;

    // Cursor address flag and line bases
    localparam logic [7:0] DDRAM_FLAG = 8'h80;
    localparam logic [7:0] LINE2_BASE = 8'h40;
    localparam logic [7:0] LINE3_BASE = 8'h14;
    localparam logic [7:0] LINE4_BASE = 8'h54;

    typedef enum logic [1:0] {
        NIB_BYTE_HI,
        NIB_BYTE_LO,
        NIB_CONST
    } t_nib_src;

    typedef enum logic [1:0] {
        RS_KEEP,
        RS_CMD,
        RS_REQ
    } t_rs_sel;

    typedef enum logic [1:0] {
        EXTRA_NONE,
        EXTRA_150,
        EXTRA_2000,
        EXTRA_5000
    } t_extra;

    // One control word per nibble step
    typedef struct packed {
        t_nib_src   src;
        logic [3:0] nib;
        t_rs_sel    rs;
        t_extra     extra;
        logic       last;
    } t_ctrl;

    // Extra wait appended to the enable-low segment of a step
    function automatic logic [HOLD_W-1:0] extra_us(input t_extra e);
        logic [HOLD_W-1:0] v;
        unique case (e)
            EXTRA_NONE: v = 13'd0;
            EXTRA_150:  v = 13'd150;
            EXTRA_2000: v = 13'd2000;
            EXTRA_5000: v = 13'd5000;
            default:    v = 13'd0;
        endcase
        return v;
    endfunction

    // Cursor base address of a 1-based display line
    function automatic logic [7:0] line_base(input logic [7:0] line);
        logic [7:0] v;
        unique case (line)
            8'd2:    v = LINE2_BASE;
            8'd3:    v = LINE3_BASE;
            8'd4:    v = LINE4_BASE;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Microprogram ROM
    function automatic t_ctrl rom_word(input logic [PC_W-1:0] pc);
        t_ctrl w;
        unique case (pc)
            // byte from the request register
            4'd0:  w = '{NIB_BYTE_HI, 4'h0, RS_REQ,  EXTRA_NONE, 1'b0};
            4'd1:  w = '{NIB_BYTE_LO, 4'h0, RS_KEEP, EXTRA_NONE, 1'b1};
            // clear display
            4'd2:  w = '{NIB_CONST,   4'h0, RS_CMD,  EXTRA_NONE, 1'b0};
            4'd3:  w = '{NIB_CONST,   4'h1, RS_KEEP, EXTRA_2000, 1'b1};
            // wake-up nibbles at the current select level
            4'd4:  w = '{NIB_CONST,   4'h3, RS_KEEP, EXTRA_5000, 1'b0};
            4'd5:  w = '{NIB_CONST,   4'h3, RS_KEEP, EXTRA_150,  1'b0};
            4'd6:  w = '{NIB_CONST,   4'h3, RS_KEEP, EXTRA_150,  1'b0};
            4'd7:  w = '{NIB_CONST,   4'h2, RS_KEEP, EXTRA_NONE, 1'b0};
            // function set, 4-bit two lines
            4'd8:  w = '{NIB_CONST,   4'h2, RS_CMD,  EXTRA_NONE, 1'b0};
            4'd9:  w = '{NIB_CONST,   4'h8, RS_KEEP, EXTRA_NONE, 1'b0};
            // display on
            4'd10: w = '{NIB_CONST,   4'h0, RS_CMD,  EXTRA_NONE, 1'b0};
            4'd11: w = '{NIB_CONST,   4'hC, RS_KEEP, EXTRA_NONE, 1'b0};
            // clear
            4'd12: w = '{NIB_CONST,   4'h0, RS_CMD,  EXTRA_NONE, 1'b0};
            4'd13: w = '{NIB_CONST,   4'h1, RS_KEEP, EXTRA_2000, 1'b0};
            // entry mode
            4'd14: w = '{NIB_CONST,   4'h0, RS_CMD,  EXTRA_NONE, 1'b0};
            4'd15: w = '{NIB_CONST,   4'h6, RS_KEEP, EXTRA_NONE, 1'b1};
            default: w = '{NIB_CONST, 4'h0, RS_KEEP, EXTRA_NONE, 1'b1};
        endcase
        return w;
    endfunction

endpackage

FILE: design/char_lcd_4bit_write_sequencer_core.sv
// Top level of the 4-bit character LCD write sequencer.
//
// Requests enter on i_valid / o_stall with fields i_op, i_byte_value,
// i_line and i_column. Pin segments leave on o_valid / i_stall, one per
// transaction, with o_last_segment marking the end of a request.
// Timing registers are written on i_cfg_valid / o_cfg_ready; the port is
// always ready and writes take effect in the following cycle.
// A request is taken only while no program runs; its first segment goes
// to the output register once the program has started and that register
// is free. Each nibble step emits two segments, one per cycle while the
// output is not stalled: 4 segments for a byte or clear, 24 for init.
// Busy drops with the last segment. Unused op codes are dropped and
// produce nothing.
// A stalled segment holds in the output register and the program waits;
// the last segment of a request may wait there while the next request is
// accepted.
// Reset returns the timing registers to 2 us and 50 us, the select level
// to command, and the block to idle with no segment pending.
module char_lcd_4bit_write_sequencer_core
    import lcd4_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_op,
    input  logic [7:0]  i_byte_value,
    input  logic [7:0]  i_line,
    input  logic [7:0]  i_column,
    // segment channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_rs_pin,
    output logic        o_rw_pin,
    output logic        o_enable_pin,
    output logic [3:0]  o_data_nibble,
    output logic [12:0] o_hold_us,
    output logic        o_last_segment,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [9:0]  i_cfg_data
);

    logic [7:0]        r_enable_high;
    logic [9:0]        r_enable_settle;
    logic              r_rs_level;
    logic              r_busy;
    logic [PC_W-1:0]   r_pc;
    logic              r_phase;
    logic [7:0]        r_byte;
    logic              r_rs_req;

    logic              r_out_valid;
    logic              r_out_rs;
    logic              r_out_en;
    logic [3:0]        r_out_nib;
    logic [HOLD_W-1:0] r_out_hold;
    logic              r_out_last;

    t_ctrl             n_ctrl;
    logic              n_rs;
    logic [3:0]        n_nib;
    logic [HOLD_W-1:0] n_hold;
    logic              n_emit;
    logic              n_accept;
    logic [7:0]        n_goto;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_busy;
    assign n_accept    = i_valid && !r_busy;
    assign n_emit      = r_busy && (!r_out_valid || !i_stall);

    // Decode the current control word
    always_comb begin
        n_ctrl = rom_word(r_pc);
        unique case (n_ctrl.rs)
            RS_KEEP: n_rs = r_rs_level;
            RS_CMD:  n_rs = 1'b0;
            RS_REQ:  n_rs = r_rs_req;
            default: n_rs = r_rs_level;
        endcase
        // the select level only changes on the first segment of a step
        if (r_phase) begin
            n_rs = r_rs_level;
        end
        unique case (n_ctrl.src)
            NIB_BYTE_HI: n_nib = r_byte[7:4];
            NIB_BYTE_LO: n_nib = r_byte[3:0];
            NIB_CONST:   n_nib = n_ctrl.nib;
            default:     n_nib = n_ctrl.nib;
        endcase
        if (r_phase) begin
            n_hold = {3'd0, r_enable_settle} + extra_us(n_ctrl.extra);
        end else begin
            n_hold = {5'd0, r_enable_high};
        end
    end

    // Cursor address from line and column, wrapping at 8 bits
    assign n_goto = DDRAM_FLAG | (line_base(i_line) + i_column - 8'd1);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_high   <= ENABLE_HIGH_RESET;
            r_enable_settle <= ENABLE_SETTLE_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_ENABLE_HIGH) begin
                r_enable_high <= i_cfg_data[7:0];
            end else begin
                r_enable_settle <= i_cfg_data;
            end
        end
    end

    // Sequencer: dispatch on accept, advance one segment per free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_pc       <= ENTRY_BYTE;
            r_phase    <= 1'b0;
            r_rs_level <= 1'b0;
        end else begin
            if (n_accept) begin
                r_phase <= 1'b0;
                case (i_op)
                    OP_CMD: begin
                        r_busy   <= 1'b1;
                        r_pc     <= ENTRY_BYTE;
                        r_byte   <= i_byte_value;
                        r_rs_req <= 1'b0;
                    end
                    OP_DATA: begin
                        r_busy   <= 1'b1;
                        r_pc     <= ENTRY_BYTE;
                        r_byte   <= i_byte_value;
                        r_rs_req <= 1'b1;
                    end
                    OP_GOTO: begin
                        r_busy   <= 1'b1;
                        r_pc     <= ENTRY_BYTE;
                        r_byte   <= n_goto;
                        r_rs_req <= 1'b0;
                    end
                    OP_CLEAR: begin
                        r_busy <= 1'b1;
                        r_pc   <= ENTRY_CLEAR;
                    end
                    OP_INIT: begin
                        r_busy <= 1'b1;
                        r_pc   <= ENTRY_INIT;
                    end
                    default: begin
                        r_busy <= 1'b0;
                    end
                endcase
            end else if (n_emit) begin
                r_rs_level <= n_rs;
                if (!r_phase) begin
                    r_phase <= 1'b1;
                end else begin
                    r_phase <= 1'b0;
                    if (n_ctrl.last) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_pc <= r_pc + 1'b1;
                    end
                end
            end
        end
    end

    // Output register: load a segment, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_emit) begin
            r_out_rs   <= n_rs;
            r_out_en   <= !r_phase;
            r_out_nib  <= n_nib;
            r_out_hold <= n_hold;
            r_out_last <= r_phase && n_ctrl.last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_rs_pin       = r_out_rs;
    assign o_rw_pin       = 1'b0;
    assign o_enable_pin   = r_out_en;
    assign o_data_nibble  = r_out_nib;
    assign o_hold_us      = r_out_hold;
    assign o_last_segment = r_out_last;

endmodule

FILE: design/lcd4_checker.sv
// Port-level checker for the 4-bit character LCD sequencer, with its bind.
`include "assert_macros.svh"

module lcd4_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_rw_pin,
    input logic        o_enable_pin,
    input logic [3:0]  o_data_nibble,
    input logic [12:0] o_hold_us,
    input logic        o_last_segment
);

    // Bus is write-only
    `ASSERT_ALWAYS(a_write_only, !o_valid || !o_rw_pin, "rw pin driven high")

    // A strobe never ends a request
    `ASSERT_SAME(a_high_not_last, o_valid && o_enable_pin, !o_last_segment,
        "enable-high segment marked last")

    // Every strobe is followed at once by its falling half with the same nibble
    `ASSERT_NEXT(a_strobe_pair, o_valid && !i_stall && o_enable_pin,
        o_valid && !o_enable_pin && o_data_nibble == $past(o_data_nibble),
        "enable-high segment not followed by its enable-low segment")

    // No new request is taken while a request is still mid-stream
    `ASSERT_SAME(a_busy_mid_request, o_valid && !o_last_segment, o_stall,
        "request accepted before the previous one finished")

    // A stalled transaction holds its data nibble and hold time
    `ASSERT_NEXT(a_stall_hold, o_valid && i_stall,
        o_valid && $stable(o_data_nibble) && $stable(o_hold_us),
        "stalled segment changed")

endmodule

bind char_lcd_4bit_write_sequencer_core lcd4_checker u_lcd4_checker (.*);
